// ----- sv/dfq_pkg.sv -----
`timescale 1ns / 1ps

package dfq_pkg;

  localparam int MAX_DIGITS_DEFAULT = 9;
  localparam int TABLE_ROWS = 9;

  localparam logic [31:0] SPREAD_EACH = 32'h0000_0006;
  localparam logic [31:0] SPREAD_REST = 32'h0000_0003;
  localparam logic [31:0] TABLE_BIAS  = 32'h0000_0001;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic MODE_WEIGHTED = 1'b0;
  localparam logic MODE_TABLE    = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [3:0] pos;
    logic [3:0] digit;
  } term_req_t;

  // Truncated weight of one tenth raised to the position plus one.
  function automatic logic [31:0] weight(input logic [3:0] pos);
    logic [31:0] w;
    case (pos)
      4'd0: w = 32'h1999_9999;
      4'd1: w = 32'h028f_5c28;
      4'd2: w = 32'h0041_8937;
      4'd3: w = 32'h0006_8db8;
      4'd4: w = 32'h0000_a7c5;
      4'd5: w = 32'h0000_10c6;
      4'd6: w = 32'h0000_01ad;
      4'd7: w = 32'h0000_002a;
      4'd8: w = 32'h0000_0004;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

  localparam logic [31:0] DIGIT_TAB [TABLE_ROWS][10] = '{
    '{32'h00000000, 32'h1999999A, 32'h33333333, 32'h4CCCCCCD, 32'h66666667,
      32'h80000000, 32'h9999999A, 32'hB3333333, 32'hCCCCCCCD, 32'hE6666667},
    '{32'h00000000, 32'h028F5C29, 32'h051EB852, 32'h07AE147B, 32'h0A3D70A4,
      32'h0CCCCCCD, 32'h0F5C28F6, 32'h11EB851F, 32'h147AE148, 32'h170A3D71},
    '{32'h00000000, 32'h00418937, 32'h0083126F, 32'h00C49BA6, 32'h010624DD,
      32'h0147AE14, 32'h0189374C, 32'h01CAC083, 32'h020C49BA, 32'h024DD2F2},
    '{32'h00000000, 32'h00068DB9, 32'h000D1B71, 32'h0013A92A, 32'h001A36E3,
      32'h0020C49C, 32'h00275254, 32'h002DE00D, 32'h00346DC6, 32'h003AFB7F},
    '{32'h00000000, 32'h0000A7C6, 32'h00014F8B, 32'h0001F751, 32'h00029F17,
      32'h000346DC, 32'h0003EEA2, 32'h00049668, 32'h00053E2D, 32'h0005E5F3},
    '{32'h00000000, 32'h000010C7, 32'h0000218E, 32'h00003255, 32'h0000431C,
      32'h000053E3, 32'h000064AA, 32'h00007571, 32'h00008638, 32'h000096FF},
    '{32'h00000000, 32'h000001AD, 32'h0000035B, 32'h00000508, 32'h000006B6,
      32'h00000863, 32'h00000A11, 32'h00000BBE, 32'h00000D6C, 32'h00000F19},
    '{32'h00000000, 32'h0000002B, 32'h00000056, 32'h00000081, 32'h000000AC,
      32'h000000D7, 32'h00000102, 32'h0000012D, 32'h00000158, 32'h00000183},
    '{32'h00000000, 32'h00000004, 32'h00000009, 32'h0000000D, 32'h00000011,
      32'h00000015, 32'h0000001A, 32'h0000001E, 32'h00000022, 32'h00000027}
  };

  function automatic logic [31:0] digit_entry(input logic [3:0] pos,
                                              input logic [3:0] digit);
    logic [31:0] e;
    e = 32'h0000_0000;
    if (pos < 4'(TABLE_ROWS) && digit < 4'd10) begin
      e = DIGIT_TAB[pos][digit];
    end
    return e;
  endfunction

endpackage

// ----- sv/decimal_fraction_to_q32.sv -----
`timescale 1ns / 1ps
// Timing: a character is registered on acceptance and folded into the sum at the
// next edge; the result of a terminating NUL is registered when the NUL leaves the hold register.
// Throughput: one character per cycle, set by one table lookup or narrow multiply and
// one 32-bit add; a NUL stalls only while the previous result is still unaccepted.
// Reset (synchronous, active high) clears the sum, the string state and the mode.

module decimal_fraction_to_q32 #(
  parameter int MAX_DIGITS = dfq_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fraction_value,
  output logic [3:0]  digits_taken,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        conversion_mode
);

  logic       mode;
  logic       hold_valid;
  logic [7:0] hold_char;
  logic       step;

  // A held NUL must wait for the result register; other characters never stall.
  assign step     = hold_valid &&
                    ((hold_char != dfq_pkg::CHAR_NUL) || !out_valid || out_ready);
  assign in_ready = !hold_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= dfq_pkg::MODE_WEIGHTED;
      hold_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= conversion_mode;
      end
      if (in_ready) begin
        hold_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char <= char_code;
    end
  end

  dfq_accum #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .char_code      (hold_char),
    .mode           (mode),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .fraction_value (fraction_value),
    .digits_taken   (digits_taken)
  );

endmodule

// ----- sv/dfq_term.sv -----
`timescale 1ns / 1ps

module dfq_term (
  input  dfq_pkg::term_req_t req,
  output logic [31:0]        addend
);

  logic [31:0] product;

  // The product wraps at 32 bits, as the sum does.
  assign product = dfq_pkg::weight(req.pos) * {28'd0, req.digit};

  always_comb begin
    case (req.mode)
      dfq_pkg::MODE_TABLE: addend = dfq_pkg::digit_entry(req.pos, req.digit);
      default: addend = product + dfq_pkg::SPREAD_EACH;
    endcase
  end

endmodule

// ----- sv/dfq_accum.sv -----
`timescale 1ns / 1ps

module dfq_accum #(
  parameter int MAX_DIGITS = dfq_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  char_code,
  input  logic        mode,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] fraction_value,
  output logic [3:0]  digits_taken
);

  logic [31:0] running_sum;
  logic [3:0]  digit_position;
  logic        digits_stopped;
  logic        string_nonempty;

  logic               is_nul;
  logic               is_digit;
  logic               take;
  dfq_pkg::term_req_t req;
  logic [31:0]        addend;
  logic [31:0]        bias;

  assign is_nul   = (char_code == dfq_pkg::CHAR_NUL);
  assign is_digit = (char_code >= dfq_pkg::CHAR_ZERO) && (char_code <= dfq_pkg::CHAR_NINE);
  assign take     = !digits_stopped && is_digit && (digit_position < 4'(MAX_DIGITS));

  // For the characters 0 through 9 the low nibble is the digit value.
  assign req.mode   = mode;
  assign req.pos    = digit_position;
  assign req.digit  = char_code[3:0];

  dfq_term u_term (
    .req    (req),
    .addend (addend)
  );

  assign bias = (mode == dfq_pkg::MODE_TABLE) ? dfq_pkg::TABLE_BIAS : dfq_pkg::SPREAD_REST;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= 32'd0;
      digit_position  <= 4'd0;
      digits_stopped  <= 1'b0;
      string_nonempty <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (is_nul) begin
          // The terminator emits the result and clears the string state.
          out_valid       <= 1'b1;
          fraction_value  <= string_nonempty ? running_sum + bias : 32'd0;
          digits_taken    <= digit_position;
          running_sum     <= 32'd0;
          digit_position  <= 4'd0;
          digits_stopped  <= 1'b0;
          string_nonempty <= 1'b0;
        end else begin
          string_nonempty <= 1'b1;
          if (!digits_stopped && !is_digit) begin
            digits_stopped <= 1'b1;
          end
          if (take) begin
            running_sum    <= running_sum + addend;
            digit_position <= digit_position + 4'd1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/decimal_fraction_to_q32_tb.sv -----
`timescale 1ns / 1ps

module decimal_fraction_to_q32_tb;

  localparam int MAX_DIGITS    = dfq_pkg::MAX_DIGITS_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_CHARS  = 1450;

  typedef struct packed {
    logic [31:0] fraction;
    logic [3:0]  digits;
  } fraction_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] fraction_value;
  logic [3:0]  digits_taken;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        conversion_mode = 1'b0;

  // Shadow of the converter: mode register and the string in progress.
  logic        mode_shadow;
  logic [31:0] sum_shadow;
  int          digits_shadow;
  logic        stopped_shadow;
  logic        nonempty_shadow;

  fraction_result_t expected_fractions[$];
  int mismatch_count = 0;
  int chars_sent = 0;
  int cycle_count = 0;
  logic no_stalls = 1'b0;

  decimal_fraction_to_q32 dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .fraction_value (fraction_value),
    .digits_taken   (digits_taken),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .conversion_mode(conversion_mode)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("decimal_fraction_to_q32_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (no_stalls || $urandom_range(0, 99) >= 7);
  end

  // Contribution of one digit at a given place, 2^32 scaled.
  // Table mode takes the fixed per-digit table, whose entries are the rounded
  // place values with a few first-place entries rounded up; weighted mode
  // truncates the place weight first and adds the spread share of the lost
  // remainder.
  function automatic logic [31:0] digit_term(input logic mode, input int pos,
                                             input int d);
    logic [63:0] scale;
    logic [63:0] num;
    scale = 64'd1;
    for (int i = 0; i <= pos; i++) begin
      scale = scale * 64'd10;
    end
    if (mode == dfq_pkg::MODE_TABLE) begin
      return dfq_pkg::DIGIT_TAB[pos][d];
    end
    num = 64'(d) * ((64'h1 << 32) / scale);
    return 32'(num) + dfq_pkg::SPREAD_EACH;
  endfunction

  function automatic void clear_shadow_string();
    sum_shadow      = 32'h0;
    digits_shadow   = 0;
    stopped_shadow  = 1'b0;
    nonempty_shadow = 1'b0;
  endfunction

  function automatic void accumulate_char(input logic [7:0] c);
    fraction_result_t r;
    if (c == dfq_pkg::CHAR_NUL) begin
      r.fraction = 32'h0;
      if (nonempty_shadow) begin
        r.fraction = sum_shadow + ((mode_shadow == dfq_pkg::MODE_TABLE) ?
                                   dfq_pkg::TABLE_BIAS : dfq_pkg::SPREAD_REST);
      end
      r.digits = 4'(digits_shadow);
      expected_fractions.push_back(r);
      clear_shadow_string();
    end else begin
      nonempty_shadow = 1'b1;
      if (!stopped_shadow) begin
        if (c < dfq_pkg::CHAR_ZERO || c > dfq_pkg::CHAR_NINE) begin
          stopped_shadow = 1'b1;
        end else if (digits_shadow < MAX_DIGITS) begin
          sum_shadow = sum_shadow + digit_term(mode_shadow, digits_shadow,
                                               int'(c - dfq_pkg::CHAR_ZERO));
          digits_shadow++;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    fraction_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_fractions.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual fraction %h digits %0d",
                 $time, fraction_value, digits_taken);
        mismatch_count++;
      end else begin
        exp_r = expected_fractions.pop_front();
        if (fraction_value !== exp_r.fraction) begin
          $display("%0t: fraction_value expected %h actual %h",
                   $time, exp_r.fraction, fraction_value);
          mismatch_count++;
        end
        if (digits_taken !== exp_r.digits) begin
          $display("%0t: digits_taken expected %0d actual %0d",
                   $time, exp_r.digits, digits_taken);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (!no_stalls && $urandom_range(0, 99) < 7) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap = $urandom_range(0, 2);
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(8'(s[i]));
    end
  endtask

  // The mode may change inside a string, so the last character is given time
  // to reach the sum before the write goes in.
  task automatic write_mode(input logic m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid       <= 1'b1;
    conversion_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_shadow = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_and_no_digits();
    send_char(dfq_pkg::CHAR_NUL);
    send_char(8'hFF);
    send_char(dfq_pkg::CHAR_NUL);
    write_mode(dfq_pkg::MODE_TABLE);
    send_char(dfq_pkg::CHAR_ZERO - 8'd1);
    send_text("7");
    send_char(dfq_pkg::CHAR_NUL);
    send_char(dfq_pkg::CHAR_NUL);
  endtask

  task automatic test_digit_bounds();
    send_text("0");
    send_char(dfq_pkg::CHAR_NINE + 8'd1);
    send_text("5");
    send_char(dfq_pkg::CHAR_NUL);
    write_mode(dfq_pkg::MODE_WEIGHTED);
    send_text("9");
    send_char(8'h01);
    send_char(dfq_pkg::CHAR_NUL);
  endtask

  task automatic test_long_with_mode_switch();
    send_text("9999");
    write_mode(dfq_pkg::MODE_TABLE);
    send_text("999999");
    send_char(dfq_pkg::CHAR_NUL);
  endtask

  task automatic test_random_strings();
    int kind;
    int count;
    int target;
    target = chars_sent + RANDOM_CHARS;
    while (chars_sent < target) begin
      no_stalls = (chars_sent >= target - 900) && (chars_sent < target - 600);
      if ($urandom_range(0, 5) == 0) write_mode(1'($urandom_range(0, 1)));
      kind = $urandom_range(0, 9);
      if (kind == 1) begin
        count = $urandom_range(1, 6);
        repeat (count) send_char(8'($urandom_range(1, 255)));
      end else if (kind != 0) begin
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 39) == 0) write_mode(1'($urandom_range(0, 1)));
          send_char(dfq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0) begin
          count = $urandom_range(1, 4);
          repeat (count) send_char(8'($urandom_range(1, 255)));
        end
      end
      send_char(dfq_pkg::CHAR_NUL);
    end
    no_stalls = 1'b0;
  endtask

  initial begin
    mode_shadow = dfq_pkg::MODE_WEIGHTED;
    clear_shadow_string();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_no_digits();
    test_digit_bounds();
    test_long_with_mode_switch();
    test_random_strings();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("decimal_fraction_to_q32_tb: PASS");
    end else begin
      $display("decimal_fraction_to_q32_tb: FAIL");
    end
    $finish;
  end

endmodule
